FILE: design/rgbhsv_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the RGB to HSV converter.
// Depends on nothing; every other file of the block imports it.
package rgbhsv_pkg;

  // Channel width and the number of fraction bits of a hue degree.
  localparam int CHANNEL_BITS      = 8;
  localparam int HUE_FRACTION_BITS = 4;

  localparam int CH_MAX     = (1 << CHANNEL_BITS) - 1;
  localparam int HUE_SIXTY  = 60 << HUE_FRACTION_BITS;
  localparam int HUE_CIRCLE = 360 << HUE_FRACTION_BITS;

  localparam int HUE_W     = $clog2(HUE_CIRCLE);
  localparam int HUE_Q_W   = $clog2(HUE_SIXTY + 1);
  localparam int SAT_Q_W   = CHANNEL_BITS;
  localparam int SAT_NUM_W = 2 * CHANNEL_BITS;
  localparam int HUE_NUM_W = CHANNEL_BITS + HUE_Q_W;

  // Restoring division: one quotient bit per step, two steps per stage.
  localparam int DIV_STEPS       = (HUE_Q_W > SAT_Q_W) ? HUE_Q_W : SAT_Q_W;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = (DIV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  typedef enum logic [1:0] {
    SECTOR_RED,
    SECTOR_GREEN,
    SECTOR_BLUE
  } sector_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } hsv_pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]        hue;
    logic [CHANNEL_BITS-1:0] saturation;
    logic [CHANNEL_BITS-1:0] brightness;
    logic                    hue_undefined;
  } hsv_result_t;

  // Everything that travels through the divider stages.
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] brightness;
    logic                    undefined;
    sector_t                 sector;
    logic                    hue_neg;
    logic [SAT_NUM_W-1:0]    sat_rem;
    logic [CHANNEL_BITS-1:0] sat_den;
    logic [SAT_Q_W-1:0]      sat_q;
    logic [HUE_NUM_W-1:0]    hue_rem;
    logic [CHANNEL_BITS-1:0] hue_den;
    logic [HUE_Q_W-1:0]      hue_q;
  } hsv_work_t;

endpackage

FILE: design/rgbhsv_div_stage.sv
`timescale 1ns / 1ps
// One register stage of the two restoring dividers (saturation and hue).
// Depends on rgbhsv_pkg for the work record and the divider widths.
module rgbhsv_div_stage #(
  parameter int STAGE_IDX = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  logic                  in_valid,
  input  rgbhsv_pkg::hsv_work_t in_work,
  output logic                  out_valid,
  output rgbhsv_pkg::hsv_work_t out_work
);
  import rgbhsv_pkg::*;

  hsv_work_t work_nxt;
  hsv_work_t work_r;
  logic      valid_r;

  // Each step tries the divisor shifted to the current quotient bit; the
  // dividend is known to stay below the divisor shifted one place further.
  always_comb begin
    logic [HUE_NUM_W-1:0] hue_sub;
    logic [SAT_NUM_W-1:0] sat_sub;
    int                   p;
    work_nxt = in_work;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      p = DIV_STEPS - 1 - (STAGE_IDX * STEPS_PER_STAGE + j);
      hue_sub = HUE_NUM_W'(work_nxt.hue_den) << p;
      sat_sub = SAT_NUM_W'(work_nxt.sat_den) << p;
      if (p >= 0 && p < HUE_Q_W) begin
        if (work_nxt.hue_rem >= hue_sub) begin
          work_nxt.hue_rem = work_nxt.hue_rem - hue_sub;
          work_nxt.hue_q   = {work_nxt.hue_q[HUE_Q_W-2:0], 1'b1};
        end else begin
          work_nxt.hue_q   = {work_nxt.hue_q[HUE_Q_W-2:0], 1'b0};
        end
      end
      if (p >= 0 && p < SAT_Q_W) begin
        if (work_nxt.sat_rem >= sat_sub) begin
          work_nxt.sat_rem = work_nxt.sat_rem - sat_sub;
          work_nxt.sat_q   = {work_nxt.sat_q[SAT_Q_W-2:0], 1'b1};
        end else begin
          work_nxt.sat_q   = {work_nxt.sat_q[SAT_Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

endmodule

FILE: design/rgb_to_hsv_converter.sv
`timescale 1ns / 1ps
// Top level of the RGB to HSV converter: front end, divider pipeline, output.
// Depends on rgbhsv_pkg and rgbhsv_div_stage.
//
// The converter turns one RGB pixel per request into hue, saturation and
// brightness, and takes a new request in every clock cycle in which in_stall
// is low. Each request passes through DIV_STAGES + 3 register stages (eight
// with 8-bit channels): the first finds the largest and smallest channel and
// the hue sector, the second forms the scaled dividends, DIV_STAGES stages run
// two restoring division steps each for saturation and hue side by side, and
// the last applies the sector offset and the wrap below zero into the output
// register. That division pipeline sets the latency; throughput is one result
// per cycle while out_stall is low. Every stage keeps its own valid bit and
// loads whenever it is empty or the stage after it moves, so bubbles close up
// and a stalled output holds its result while earlier stages keep filling.
// The input stall is raised only when every stage holds a request and the
// output is stalled. Ties for the largest channel go to red, then green.
// When all three channels are equal, hue and saturation read zero and
// hue_undefined is set. Hue is in sixteenths of a degree, 0 to 5759.
module rgb_to_hsv_converter (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  rgbhsv_pkg::hsv_pixel_t  in_pixel,
  output logic                    out_valid,
  input  logic                    out_stall,
  output rgbhsv_pkg::hsv_result_t out_result
);
  import rgbhsv_pkg::*;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] brightness;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] diff;
    logic                    neg;
    sector_t                 sector;
  } hsv_front_t;

  hsv_front_t  front_nxt, front_r;
  logic        front_valid_r;
  hsv_work_t   prep_nxt, prep_r;
  logic        prep_valid_r;
  hsv_work_t   div_work  [0:DIV_STAGES];
  logic        div_valid [0:DIV_STAGES];
  hsv_result_t out_result_nxt, out_result_r;
  logic        out_valid_r;

  logic                  ld_front, ld_prep, ld_out;
  logic [DIV_STAGES-1:0] ld_div;

  // Load enables, from the output back to the input. A stage loads when it
  // is empty or when its contents move on in the same cycle.
  always_comb begin
    ld_out = !out_valid_r || !out_stall;
    ld_div[DIV_STAGES-1] = !div_valid[DIV_STAGES] || ld_out;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      ld_div[k] = !div_valid[k+1] || ld_div[k+1];
    end
    ld_prep  = !prep_valid_r || ld_div[0];
    ld_front = !front_valid_r || ld_prep;
  end

  assign in_stall = !ld_front;

  // Stage one: largest and smallest channel, and the hue sector. The
  // sector picks which two channels are compared and in which direction.
  always_comb begin
    logic [CHANNEL_BITS-1:0] mx, mn, a, b;
    mx = (in_pixel.red > in_pixel.green) ? in_pixel.red : in_pixel.green;
    mx = (mx > in_pixel.blue) ? mx : in_pixel.blue;
    mn = (in_pixel.red < in_pixel.green) ? in_pixel.red : in_pixel.green;
    mn = (mn < in_pixel.blue) ? mn : in_pixel.blue;
    if (in_pixel.red >= mx) begin
      front_nxt.sector = SECTOR_RED;
      a = in_pixel.green;
      b = in_pixel.blue;
    end else if (in_pixel.green >= mx) begin
      front_nxt.sector = SECTOR_GREEN;
      a = in_pixel.blue;
      b = in_pixel.red;
    end else begin
      front_nxt.sector = SECTOR_BLUE;
      a = in_pixel.red;
      b = in_pixel.green;
    end
    front_nxt.brightness = mx;
    front_nxt.delta      = mx - mn;
    front_nxt.neg        = (a < b);
    front_nxt.diff       = (a < b) ? (b - a) : (a - b);
  end

  // Stage two: scaled dividends. Saturation divides full scale times delta
  // by the brightness; hue divides sixty degrees times the channel
  // difference by delta.
  always_comb begin
    prep_nxt            = '0;
    prep_nxt.brightness = front_r.brightness;
    prep_nxt.undefined  = (front_r.delta == '0);
    prep_nxt.sector     = front_r.sector;
    prep_nxt.hue_neg    = front_r.neg;
    prep_nxt.sat_rem    = SAT_NUM_W'(CH_MAX) * SAT_NUM_W'(front_r.delta);
    prep_nxt.sat_den    = front_r.brightness;
    prep_nxt.hue_rem    = HUE_NUM_W'(HUE_SIXTY) * HUE_NUM_W'(front_r.diff);
    prep_nxt.hue_den    = front_r.delta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
      prep_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (ld_front) begin
        front_valid_r <= in_valid;
      end
      if (ld_prep) begin
        prep_valid_r <= front_valid_r;
      end
      if (ld_out) begin
        out_valid_r <= div_valid[DIV_STAGES];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_front) begin
      front_r <= front_nxt;
    end
    if (ld_prep) begin
      prep_r <= prep_nxt;
    end
    if (ld_out) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign div_work[0]  = prep_r;
  assign div_valid[0] = prep_valid_r;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    rgbhsv_div_stage #(
      .STAGE_IDX (k)
    ) u_div_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (ld_div[k]),
      .in_valid  (div_valid[k]),
      .in_work   (div_work[k]),
      .out_valid (div_valid[k+1]),
      .out_work  (div_work[k+1])
    );
  end

  // Last stage: add or subtract the hue fraction from the sector offset.
  // Only the red sector can go below zero, and then a full circle is added.
  always_comb begin
    hsv_work_t        w;
    logic [HUE_W-1:0] offset, q, hue;
    w = div_work[DIV_STAGES];
    case (w.sector)
      SECTOR_RED:   offset = '0;
      SECTOR_GREEN: offset = HUE_W'(2 * HUE_SIXTY);
      SECTOR_BLUE:  offset = HUE_W'(4 * HUE_SIXTY);
      default:      offset = '0;
    endcase
    q = HUE_W'(w.hue_q);
    if (!w.hue_neg) begin
      hue = offset + q;
    end else if (offset >= q) begin
      hue = offset - q;
    end else begin
      hue = offset + HUE_W'(HUE_CIRCLE) - q;
    end
    out_result_nxt.brightness    = w.brightness;
    out_result_nxt.hue_undefined = w.undefined;
    out_result_nxt.hue           = w.undefined ? '0 : hue;
    out_result_nxt.saturation    = w.undefined ? '0 : w.sat_q;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

FILE: design/rgbhsv_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the RGB to HSV converter, bound to its top level.
// Depends on rgbhsv_pkg and on the ports of rgb_to_hsv_converter.
module rgbhsv_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input rgbhsv_pkg::hsv_pixel_t  in_pixel,
  input logic                    out_valid,
  input logic                    out_stall,
  input rgbhsv_pkg::hsv_result_t out_result
);
  import rgbhsv_pkg::*;

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");

  // The pipeline only pushes back on the input when the output is stalled.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output was free");

  // Grey pixels report zero hue and saturation.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.hue_undefined |->
      out_result.hue == '0 && out_result.saturation == '0)
    else $error("grey pixel with nonzero hue or saturation");

  // A coloured pixel has a hue inside the circle and some saturation.
  a_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result.hue_undefined |->
      out_result.hue < HUE_W'(HUE_CIRCLE) && out_result.saturation != '0)
    else $error("coloured pixel with hue or saturation out of range");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RGB to HSV converter, with random idling on both sides.
// Depends on rgbhsv_pkg and rgb_to_hsv_converter from the design folder.
module testbench;
  import rgbhsv_pkg::*;

  // Hue is counted in sixteenths of a degree.
  localparam int SIXTY_DEG       = 60 * 16;
  localparam int FULL_TURN       = 360 * 16;
  localparam int CHANNEL_FULL    = 255;
  localparam int RANDOM_REQUESTS = 400;
  // The pipeline is eight stages deep, so this is ample for stray results to show up.
  localparam int SETTLE_CYCLES   = 40;
  localparam int CYCLE_LIMIT     = 200000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  hsv_pixel_t  in_pixel  = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  hsv_result_t out_result;

  // Pixels waiting to be sent, and the results still owed by the block.
  hsv_pixel_t  pixel_q[$];
  hsv_result_t hsv_expected_q[$];

  // Handshake outcomes captured at the rising edge, used by the falling-edge drivers.
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  int send_wait  = 0;
  int stall_wait = 0;
  // While a steady flag is set that side does not idle at all.
  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;

  int error_count = 0;
  int cycle_count = 0;

  rgb_to_hsv_converter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(out_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected conversion of one pixel. The largest channel picks the sector, with red
  // winning ties over green and blue, and green winning over blue.
  function automatic hsv_result_t convert_pixel(hsv_pixel_t px);
    int r, g, b, top, bottom, delta, offset, lead, trail, frac, hue;
    hsv_result_t res;
    r      = int'(px.red);
    g      = int'(px.green);
    b      = int'(px.blue);
    top    = (r > g) ? r : g;
    top    = (top > b) ? top : b;
    bottom = (r < g) ? r : g;
    bottom = (bottom < b) ? bottom : b;
    delta  = top - bottom;
    res            = '0;
    res.brightness = top[CHANNEL_BITS-1:0];
    // A grey pixel, black and white included, has no hue and no saturation.
    if (delta == 0) begin
      res.hue_undefined = 1'b1;
      return res;
    end
    frac           = (CHANNEL_FULL * delta) / top;
    res.saturation = frac[CHANNEL_BITS-1:0];
    if (r >= top) begin
      offset = 0;
      lead   = g;
      trail  = b;
    end else if (g >= top) begin
      offset = 2 * SIXTY_DEG;
      lead   = b;
      trail  = r;
    end else begin
      offset = 4 * SIXTY_DEG;
      lead   = r;
      trail  = g;
    end
    // The fraction is truncated toward zero before its sign is applied, and a
    // negative hue is wrapped round by one full turn.
    frac = (SIXTY_DEG * ((lead >= trail) ? lead - trail : trail - lead)) / delta;
    hue  = (lead >= trail) ? offset + frac : offset - frac;
    if (hue < 0) begin
      hue += FULL_TURN;
    end
    res.hue = hue[HUE_W-1:0];
    return res;
  endfunction

  task automatic add_request(int r, int g, int b);
    hsv_pixel_t px;
    px.red   = r[CHANNEL_BITS-1:0];
    px.green = g[CHANNEL_BITS-1:0];
    px.blue  = b[CHANNEL_BITS-1:0];
    pixel_q.push_back(px);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Request driver. A request is held, unchanged, until the block accepts it; after
  // each acceptance the sender draws how many cycles to idle before the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_valid) begin
        if ($urandom_range(0, 29) == 0) begin
          sender_steady = !sender_steady;
        end
        send_wait = sender_steady ? 0 : $urandom_range(0, 14);
      end
      if (send_wait == 0 && pixel_q.size() != 0) begin
        in_pixel <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (send_wait > 0) begin
          send_wait--;
        end
      end
    end
  end

  // Every accepted request owes exactly one result, predicted here at acceptance.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      hsv_expected_q.push_back(convert_pixel(in_pixel));
    end
  end

  // Result receiver. After each result it takes, it holds off for a drawn number of
  // cycles, which with long enough stalls backs the pipeline up to the input.
  always @(negedge clk) begin
    if (out_taken) begin
      if ($urandom_range(0, 29) == 0) begin
        receiver_steady = !receiver_steady;
      end
      stall_wait = receiver_steady ? 0 : $urandom_range(0, 14);
    end
    if (stall_wait > 0) begin
      out_stall <= 1'b1;
      stall_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor: each result taken is compared with the oldest prediction.
  always @(posedge clk) begin
    hsv_result_t want;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (hsv_expected_q.size() == 0) begin
        report_mismatch("result with no request outstanding, hue", int'(out_result.hue), 0);
      end else begin
        want = hsv_expected_q.pop_front();
        if (out_result.hue !== want.hue) begin
          report_mismatch("hue", int'(out_result.hue), int'(want.hue));
        end
        if (out_result.saturation !== want.saturation) begin
          report_mismatch("saturation", int'(out_result.saturation),
                          int'(want.saturation));
        end
        if (out_result.brightness !== want.brightness) begin
          report_mismatch("brightness", int'(out_result.brightness),
                          int'(want.brightness));
        end
        if (out_result.hue_undefined !== want.hue_undefined) begin
          report_mismatch("hue_undefined", int'(out_result.hue_undefined),
                          int'(want.hue_undefined));
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run, with every gap and stall at its longest.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int r, g, b, hi, lo, kind;
    int extremes[4];
    extremes[0] = 0;
    extremes[1] = 1;
    extremes[2] = CHANNEL_FULL - 1;
    extremes[3] = CHANNEL_FULL;

    // Greys: black, white and mid grey.
    add_request(0, 0, 0);
    add_request(255, 255, 255);
    add_request(128, 128, 128);
    // Primaries, and ties for the largest channel in each pairing.
    add_request(255, 0, 0);
    add_request(0, 255, 0);
    add_request(0, 0, 255);
    add_request(255, 255, 0);
    add_request(0, 255, 255);
    add_request(255, 0, 255);
    add_request(255, 128, 255);
    // Just either side of each sector boundary, including the wrap below zero.
    add_request(255, 0, 1);
    add_request(255, 1, 0);
    add_request(1, 255, 0);
    add_request(0, 255, 1);
    add_request(0, 1, 255);
    add_request(1, 0, 255);
    // Smallest possible spread, at the dark and the bright end, and a full spread.
    add_request(1, 0, 0);
    add_request(0, 0, 1);
    add_request(1, 1, 0);
    add_request(255, 254, 254);
    add_request(254, 255, 255);
    add_request(0, 255, 254);
    // A few ordinary colours.
    add_request(200, 100, 150);
    add_request(170, 85, 0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end else if (kind <= 6) begin
        // Near grey: tiny spreads, exact greys among them.
        lo = $urandom_range(0, 253);
        r  = lo + $urandom_range(0, 2);
        g  = lo + $urandom_range(0, 2);
        b  = lo + $urandom_range(0, 2);
      end else if (kind <= 8) begin
        // Two channels share the maximum, the third lies below it.
        hi = $urandom_range(1, 255);
        lo = $urandom_range(0, hi - 1);
        r  = hi;
        g  = hi;
        b  = hi;
        case ($urandom_range(0, 2))
          0: begin
            r = lo;
          end
          1: begin
            g = lo;
          end
          default: begin
            b = lo;
          end
        endcase
      end else begin
        r = extremes[2'($urandom_range(0, 3))];
        g = extremes[2'($urandom_range(0, 3))];
        b = extremes[2'($urandom_range(0, 3))];
      end
      add_request(r, g, b);
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be sent and every result to come back.
    do begin
      @(posedge clk);
    end while (pixel_q.size() != 0 || in_valid || hsv_expected_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
